// ----- rtl/core/cicv_pkg.sv -----
// Package for the settings-image CRC validator: item structs, phase and
// failure codes, register indexes and the byte-wide CRC-32 update.
// No dependencies; every other file in rtl/core uses it.
package cicv_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam int unsigned HEADER_BYTES = 8;
    localparam int unsigned CRC_BYTES    = 4;

    typedef enum logic [1:0] {
        REG_EXPECTED_MAGIC   = 2'd0,
        REG_EXPECTED_VERSION = 2'd1,
        REG_PAYLOAD_LEN      = 2'd2,
        REG_UNUSED           = 2'd3
    } t_reg_index;

    typedef enum logic [1:0] {
        FAIL_NONE    = 2'd0,
        FAIL_HEADER  = 2'd1,
        FAIL_LENGTH  = 2'd2,
        FAIL_CRC     = 2'd3
    } t_fail_reason;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_CRC     = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_image;
    } t_in_item;

    typedef struct packed {
        logic        image_valid;
        logic [1:0]  fail_reason;
        logic [31:0] computed_crc;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  reg_index;
        logic [31:0] wr_data;
    } t_cfg_item;

    // Reflected CRC-32 over one byte, least significant bit first.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                               input logic [7:0]  data);
        logic [31:0] x;
        x = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

// ----- rtl/core/cicv_stream_if.sv -----
// Valid/ready channel used for the byte input, the result output and the
// register write port. The payload type is set per instance; needs cicv_pkg.
interface cicv_stream_if #(
    parameter type T = cicv_pkg::t_in_item
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/config_image_crc_validator.sv -----
// Settings-image validator: parses header, payload and CRC bytes and checks a
// reflected CRC-32 over the payload. Uses cicv_pkg and cicv_stream_if.
// Throughput is one byte item per cycle; bytes stall only while a result item
// waits unread in the output register. A result is offered from the cycle
// after its last CRC byte is accepted. Synchronous reset zeroes the registers
// other than the result payload, sets the CRC to all ones and idles.
module config_image_crc_validator (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cicv_stream_if.sink           i_in,
    cicv_stream_if.sink           i_cfg,
    cicv_stream_if.source         o_res
);

    // Configuration registers. Writes are only expected between images, so
    // the port is always ready.
    logic [31:0] r_exp_magic;
    logic [15:0] r_exp_version;
    logic [15:0] r_payload_len;

    // Parse state.
    cicv_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_cnt, n_cnt;
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_magic, n_magic;
    logic [15:0] r_version, n_version;
    logic [15:0] r_length, n_length;
    logic [23:0] r_seen_crc, n_seen_crc;

    // Output register; it decouples the result side from the byte side.
    logic                r_out_valid, n_out_valid;
    cicv_pkg::t_out_item r_out, n_out;

    logic                in_accept;
    logic                out_free;
    logic [7:0]          b;
    cicv_pkg::t_phase    eff_phase;
    logic [15:0]         eff_cnt;
    logic [31:0]         eff_crc;
    logic [15:0]         cnt_inc;
    logic [31:0]         crc_final;
    logic [31:0]         crc_stored;
    logic [1:0]          reason;

    // A new byte may enter whenever the output register is empty or is being
    // emptied in this cycle, so results and bytes flow without bubbles.
    assign out_free    = !r_out_valid || o_res.ready;
    assign i_in.ready  = out_free;
    assign in_accept   = i_in.valid && out_free;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    assign b = i_in.payload.data_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_magic   <= '0;
            r_exp_version <= '0;
            r_payload_len <= '0;
        end else if (i_cfg.valid) begin
            unique case (cicv_pkg::t_reg_index'(i_cfg.payload.reg_index))
                cicv_pkg::REG_EXPECTED_MAGIC:   r_exp_magic   <= i_cfg.payload.wr_data;
                cicv_pkg::REG_EXPECTED_VERSION: r_exp_version <= i_cfg.payload.wr_data[15:0];
                cicv_pkg::REG_PAYLOAD_LEN:      r_payload_len <= i_cfg.payload.wr_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        // A start marker restarts the parse before the byte is interpreted,
        // so it always lands as the first magic byte.
        eff_phase = i_in.payload.start_of_image ? cicv_pkg::PH_HEADER : r_phase;
        eff_cnt   = i_in.payload.start_of_image ? 16'd0 : r_cnt;
        eff_crc   = i_in.payload.start_of_image ? cicv_pkg::CRC_INIT : r_crc;
        cnt_inc   = eff_cnt + 16'd1;

        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_crc      = r_crc;
        n_magic    = r_magic;
        n_version  = r_version;
        n_length   = r_length;
        n_seen_crc = r_seen_crc;

        crc_final  = ~eff_crc;
        crc_stored = {b, r_seen_crc};
        reason     = cicv_pkg::FAIL_NONE;

        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;

        if (in_accept) begin
            n_phase = eff_phase;
            n_cnt   = eff_cnt;
            n_crc   = eff_crc;
            unique case (eff_phase)
                cicv_pkg::PH_HEADER: begin
                    // Header bytes go into their lane by position; the
                    // fields are rewritten in full on every image.
                    case (eff_cnt[2:0])
                        3'd0: n_magic[7:0]    = b;
                        3'd1: n_magic[15:8]   = b;
                        3'd2: n_magic[23:16]  = b;
                        3'd3: n_magic[31:24]  = b;
                        3'd4: n_version[7:0]  = b;
                        3'd5: n_version[15:8] = b;
                        3'd6: n_length[7:0]   = b;
                        default: n_length[15:8] = b;
                    endcase
                    if (eff_cnt[2:0] == 3'(cicv_pkg::HEADER_BYTES - 1)) begin
                        n_cnt   = '0;
                        n_phase = (r_payload_len != 16'd0) ? cicv_pkg::PH_PAYLOAD
                                                           : cicv_pkg::PH_CRC;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
                cicv_pkg::PH_PAYLOAD: begin
                    n_crc = cicv_pkg::crc32_byte(eff_crc, b);
                    // Ends once the live length is reached or passed; a
                    // counter wrap also ends the payload.
                    if (cnt_inc >= r_payload_len || cnt_inc == 16'd0) begin
                        n_cnt   = '0;
                        n_phase = cicv_pkg::PH_CRC;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
                cicv_pkg::PH_CRC: begin
                    case (eff_cnt[1:0])
                        2'd0: n_seen_crc[7:0]   = b;
                        2'd1: n_seen_crc[15:8]  = b;
                        2'd2: n_seen_crc[23:16] = b;
                        default: ;
                    endcase
                    if (eff_cnt[1:0] == 2'(cicv_pkg::CRC_BYTES - 1)) begin
                        // Last CRC byte: checks are made in priority order
                        // against the registers as they stand now.
                        if (r_magic != r_exp_magic || r_version != r_exp_version) begin
                            reason = cicv_pkg::FAIL_HEADER;
                        end else if (r_length != r_payload_len) begin
                            reason = cicv_pkg::FAIL_LENGTH;
                        end else if (crc_final != crc_stored) begin
                            reason = cicv_pkg::FAIL_CRC;
                        end
                        n_cnt                = '0;
                        n_phase              = cicv_pkg::PH_IDLE;
                        n_out_valid          = 1'b1;
                        n_out.image_valid    = (reason == cicv_pkg::FAIL_NONE);
                        n_out.fail_reason    = reason;
                        n_out.computed_crc   = crc_final;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
                default: begin
                    // Idle without a start marker: the byte is dropped.
                    n_phase = cicv_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= cicv_pkg::PH_IDLE;
            r_cnt       <= '0;
            r_crc       <= cicv_pkg::CRC_INIT;
            r_magic     <= '0;
            r_version   <= '0;
            r_length    <= '0;
            r_seen_crc  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_crc       <= n_crc;
            r_magic     <= n_magic;
            r_version   <= n_version;
            r_length    <= n_length;
            r_seen_crc  <= n_seen_crc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

`ifndef SYNTHESIS
    // A fresh result always leaves the parser idle.
    a_result_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (r_phase == cicv_pkg::PH_IDLE))
        else $error("result issued while parse still active");

    // The valid flag and the failure code must agree.
    a_valid_matches_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.image_valid == (r_out.fail_reason == cicv_pkg::FAIL_NONE)))
        else $error("image_valid disagrees with fail_reason");

    // The header and CRC counters stay within their field lengths.
    a_header_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == cicv_pkg::PH_HEADER) |-> (r_cnt < 16'(cicv_pkg::HEADER_BYTES)))
        else $error("header byte count overran");

    a_crc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == cicv_pkg::PH_CRC) |-> (r_cnt < 16'(cicv_pkg::CRC_BYTES)))
        else $error("CRC byte count overran");
`endif

endmodule
